>>> rtl/rbei_pkg.sv
// ============================================================================
// rbei_pkg: shared types, codes and fixed-point helpers
// Operation codes, register indexes, sequencing phases and Q16.16 arithmetic.
// ============================================================================
package rbei_pkg;

    localparam int NUM_AXES = 3;
    localparam int AXIS_Y   = 1;
    localparam int DATA_W   = 32;
    localparam int DT_W     = 16;
    localparam int IMASS_W  = 31;
    localparam int DAMP_W   = 17;
    localparam int MA_W     = 33;
    localparam int MB_W     = 32;
    localparam int PROD_W   = 65;
    localparam int WIDE_W   = 66;

    typedef logic [1:0] t_op;
    localparam t_op OP_ACCEL  = 2'd0;
    localparam t_op OP_FORCE  = 2'd1;
    localparam t_op OP_STEP   = 2'd2;
    localparam t_op OP_SETPOS = 2'd3;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GRAV_EN = 2'd0;
    localparam t_cfg_idx CFG_GRAV    = 2'd1;
    localparam t_cfg_idx CFG_IMASS   = 2'd2;
    localparam t_cfg_idx CFG_DAMP    = 2'd3;

    localparam logic signed [DATA_W-1:0] GRAV_RESET  = -32'sd64684;
    localparam logic [IMASS_W-1:0]       IMASS_RESET = 31'd65536;
    localparam logic [DAMP_W-1:0]        DAMP_RESET  = 17'd65536;

    // One phase per cycle of work; every lane runs the same phase at once.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ACCEL,
        PH_SETPOS,
        PH_MUL_VI,
        PH_MUL_GDT,
        PH_ADD_ACC,
        PH_MUL_ADT,
        PH_VNEW,
        PH_MUL_VSUM,
        PH_POS_DAMP,
        PH_VEL
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic [DT_W-1:0]      dt;
        logic [IMASS_W-1:0]   inv_mass;
        logic [DAMP_W-1:0]    damping;
    } t_lane_ctl;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] x);
        if (x[WIDE_W-1:DATA_W-1] == {(WIDE_W-DATA_W+1){x[WIDE_W-1]}}) begin
            return x[DATA_W-1:0];
        end else if (x[WIDE_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] add_sat(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic signed [WIDE_W-1:0] s;
        s = WIDE_W'(a) + WIDE_W'(b);
        return sat_wide(s);
    endfunction

    // Round half toward plus infinity, drop 16 or 17 fraction bits, saturate.
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [PROD_W-1:0] p,
                                                           input logic shift17);
        logic signed [WIDE_W-1:0] q;
        q = WIDE_W'(p) + (shift17 ? WIDE_W'(65536) : WIDE_W'(32768));
        return shift17 ? sat_wide(q >>> 17) : sat_wide(q >>> 16);
    endfunction

endpackage

>>> rtl/rigid_body_euler_integrator.sv
// ============================================================================
// rigid_body_euler_integrator: three-axis point-mass integrator, Q16.16
// Trapezoidal Euler update of one body with force accumulation, gravity and
// damping, saturating arithmetic.
// ============================================================================
// Each input beat carries one operation: accelerate, add force, step or set
// position, and every beat returns one result beat with the position and
// velocity after it. Three identical lanes, one per axis, each with its own
// multiplier, work in lockstep; a sequencer here steps them through the
// phases of the operation and a merge stage registers the packed result.
// Accelerate and set position run one phase, add force a multiply and add.
// A step runs a gravity multiply and add when gravity is enabled, then the
// acceleration multiply, new velocity, mean-velocity multiply, damped
// position and velocity; dependent multiplies on the velocity set the step
// length, each product registered before it is rounded and added. The
// input is ready only when idle; the done state loads the output register,
// and a result waiting there does not block the next item from being taken.
// Configuration must be written only while the block is idle.
module rigid_body_euler_integrator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [rbei_pkg::DATA_W-1:0]        i_cfg_data,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: vec_x[31:0], vec_y[63:32], vec_z[95:64], time_step[111:96]
    input  logic [111:0]                       s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]                         s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64],
    //        vel_x[127:96], vel_y[159:128], vel_z[191:160]
    output logic [191:0]                       m_axis_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // Configuration registers.
    logic                                r_grav_en;
    logic signed [rbei_pkg::DATA_W-1:0]  r_grav;
    logic [rbei_pkg::IMASS_W-1:0]        r_imass;
    logic [rbei_pkg::DAMP_W-1:0]         r_damp;

    // Sequencer.
    t_state           r_state, n_state;
    rbei_pkg::t_phase r_phase, n_phase;
    logic             r_is_step, n_is_step;

    // Latched item.
    logic signed [rbei_pkg::DATA_W-1:0] r_vec [rbei_pkg::NUM_AXES];
    logic [rbei_pkg::DT_W-1:0]          r_dt;

    logic                               w_accept;
    logic                               w_last;
    logic                               w_can_load;
    logic                               w_load;
    rbei_pkg::t_lane_ctl                w_ctl;
    logic signed [rbei_pkg::DATA_W-1:0] w_pos [rbei_pkg::NUM_AXES];
    logic signed [rbei_pkg::DATA_W-1:0] w_vel [rbei_pkg::NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav_en <= 1'b0;
            r_grav    <= rbei_pkg::GRAV_RESET;
            r_imass   <= rbei_pkg::IMASS_RESET;
            r_damp    <= rbei_pkg::DAMP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbei_pkg::CFG_GRAV_EN: r_grav_en <= i_cfg_data[0];
                rbei_pkg::CFG_GRAV:    r_grav    <= i_cfg_data;
                rbei_pkg::CFG_IMASS:   r_imass   <= i_cfg_data[rbei_pkg::IMASS_W-1:0];
                rbei_pkg::CFG_DAMP:    r_damp    <= i_cfg_data[rbei_pkg::DAMP_W-1:0];
                default:               r_grav_en <= r_grav_en;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // The last phase of each operation; an add of the accumulator ends an
    // add force but only opens the velocity work of a step.
    assign w_last = (r_phase == rbei_pkg::PH_ACCEL) || (r_phase == rbei_pkg::PH_SETPOS)
                 || (r_phase == rbei_pkg::PH_VEL)
                 || ((r_phase == rbei_pkg::PH_ADD_ACC) && !r_is_step);

    assign w_load = (r_state == ST_DONE) && w_can_load;

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_is_step = r_is_step;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state   = ST_RUN;
                    n_is_step = (s_axis_tuser == rbei_pkg::OP_STEP);
                    case (s_axis_tuser)
                        rbei_pkg::OP_ACCEL: n_phase = rbei_pkg::PH_ACCEL;
                        rbei_pkg::OP_FORCE: n_phase = rbei_pkg::PH_MUL_VI;
                        rbei_pkg::OP_STEP:  n_phase = r_grav_en ? rbei_pkg::PH_MUL_GDT
                                                                : rbei_pkg::PH_MUL_ADT;
                        default:            n_phase = rbei_pkg::PH_SETPOS;
                    endcase
                end
            end
            ST_RUN: begin
                if (w_last) begin
                    n_state = ST_DONE;
                    n_phase = rbei_pkg::PH_IDLE;
                end else begin
                    case (r_phase)
                        rbei_pkg::PH_MUL_VI:   n_phase = rbei_pkg::PH_ADD_ACC;
                        rbei_pkg::PH_MUL_GDT:  n_phase = rbei_pkg::PH_ADD_ACC;
                        rbei_pkg::PH_ADD_ACC:  n_phase = rbei_pkg::PH_MUL_ADT;
                        rbei_pkg::PH_MUL_ADT:  n_phase = rbei_pkg::PH_VNEW;
                        rbei_pkg::PH_VNEW:     n_phase = rbei_pkg::PH_MUL_VSUM;
                        rbei_pkg::PH_MUL_VSUM: n_phase = rbei_pkg::PH_POS_DAMP;
                        rbei_pkg::PH_POS_DAMP: n_phase = rbei_pkg::PH_VEL;
                        default:               n_phase = rbei_pkg::PH_IDLE;
                    endcase
                end
            end
            ST_DONE: begin
                if (w_can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_phase = rbei_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= rbei_pkg::PH_IDLE;
            r_is_step <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_is_step <= n_is_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int a = 0; a < rbei_pkg::NUM_AXES; a++) begin
                r_vec[a] <= s_axis_tdata[a*rbei_pkg::DATA_W +: rbei_pkg::DATA_W];
            end
            r_dt <= s_axis_tdata[rbei_pkg::NUM_AXES*rbei_pkg::DATA_W +: rbei_pkg::DT_W];
        end
    end

    assign w_ctl.phase    = r_phase;
    assign w_ctl.dt       = r_dt;
    assign w_ctl.inv_mass = r_imass;
    assign w_ctl.damping  = r_damp;

    // Gravity reaches the y lane only; the other lanes multiply zero.
    for (genvar g = 0; g < rbei_pkg::NUM_AXES; g++) begin : g_lane
        rbei_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_vec   (r_vec[g]),
            .i_grav  ((g == rbei_pkg::AXIS_Y) ? r_grav : '0),
            .o_pos   (w_pos[g]),
            .o_vel   (w_vel[g])
        );
    end

    rbei_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_pos         (w_pos),
        .i_vel         (w_vel),
        .o_can_load    (w_can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // A new result appears only out of the done state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_DONE))
        else $error("result beat raised outside the done state");

    // A finished item waits while the output register is still full.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && !w_can_load |=> (r_state == ST_DONE))
        else $error("finished item left before the output register was free");

    // Set position loads the x position from the beat once its phase has run.
    a_setpos_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (s_axis_tuser == rbei_pkg::OP_SETPOS)
        |=> ##1 (w_pos[0] == $past(s_axis_tdata[31:0], 2)))
        else $error("set position did not load the x position");

endmodule

>>> rtl/rbei_lane.sv
// ============================================================================
// rbei_lane: one axis of the integrator
// Holds position, velocity and acceleration sum of one axis and applies the
// phase given by the sequencer, using one registered multiplier.
// ============================================================================
module rbei_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rbei_pkg::t_lane_ctl                 i_ctl,
    input  logic signed [rbei_pkg::DATA_W-1:0]  i_vec,
    input  logic signed [rbei_pkg::DATA_W-1:0]  i_grav,
    output logic signed [rbei_pkg::DATA_W-1:0]  o_pos,
    output logic signed [rbei_pkg::DATA_W-1:0]  o_vel
);

    logic signed [rbei_pkg::DATA_W-1:0] r_pos, n_pos;
    logic signed [rbei_pkg::DATA_W-1:0] r_vel, n_vel;
    logic signed [rbei_pkg::DATA_W-1:0] r_acc, n_acc;
    logic signed [rbei_pkg::DATA_W-1:0] r_vnew, n_vnew;
    logic signed [rbei_pkg::PROD_W-1:0] r_prod;
    logic signed [rbei_pkg::MA_W-1:0]   w_mul_a;
    logic signed [rbei_pkg::MB_W-1:0]   w_mul_b;
    logic signed [rbei_pkg::PROD_W-1:0] w_prod;
    logic signed [rbei_pkg::DATA_W-1:0] w_rnd;
    logic signed [rbei_pkg::MB_W-1:0]   w_dt_s;

    assign w_dt_s = $signed({{(rbei_pkg::MB_W-rbei_pkg::DT_W){1'b0}}, i_ctl.dt});

    // Multiplier operands for the phase now running.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_ctl.phase)
            rbei_pkg::PH_MUL_VI: begin
                w_mul_a = rbei_pkg::MA_W'(i_vec);
                w_mul_b = $signed({1'b0, i_ctl.inv_mass});
            end
            rbei_pkg::PH_MUL_GDT: begin
                w_mul_a = rbei_pkg::MA_W'(i_grav);
                w_mul_b = w_dt_s;
            end
            rbei_pkg::PH_MUL_ADT: begin
                w_mul_a = rbei_pkg::MA_W'(r_acc);
                w_mul_b = w_dt_s;
            end
            rbei_pkg::PH_MUL_VSUM: begin
                w_mul_a = rbei_pkg::MA_W'(r_vel) + rbei_pkg::MA_W'(r_vnew);
                w_mul_b = w_dt_s;
            end
            rbei_pkg::PH_POS_DAMP: begin
                w_mul_a = rbei_pkg::MA_W'(r_vnew);
                w_mul_b = $signed({{(rbei_pkg::MB_W-rbei_pkg::DAMP_W){1'b0}}, i_ctl.damping});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // The mean-velocity product carries one extra fraction bit for the halving.
    assign w_rnd = rbei_pkg::round_sat(r_prod, i_ctl.phase == rbei_pkg::PH_POS_DAMP);

    always_comb begin
        n_pos  = r_pos;
        n_vel  = r_vel;
        n_acc  = r_acc;
        n_vnew = r_vnew;
        case (i_ctl.phase)
            rbei_pkg::PH_ACCEL:    n_acc  = rbei_pkg::add_sat(r_acc, i_vec);
            rbei_pkg::PH_SETPOS:   n_pos  = i_vec;
            rbei_pkg::PH_ADD_ACC:  n_acc  = rbei_pkg::add_sat(r_acc, w_rnd);
            rbei_pkg::PH_VNEW:     n_vnew = rbei_pkg::add_sat(r_vel, w_rnd);
            rbei_pkg::PH_POS_DAMP: n_pos  = rbei_pkg::add_sat(r_pos, w_rnd);
            rbei_pkg::PH_VEL: begin
                n_vel = w_rnd;
                n_acc = '0;
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vel <= '0;
            r_acc <= '0;
        end else begin
            r_pos <= n_pos;
            r_vel <= n_vel;
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vnew <= n_vnew;
        r_prod <= w_prod;
    end

    assign o_pos = r_pos;
    assign o_vel = r_vel;

endmodule

>>> rtl/rbei_merge.sv
// ============================================================================
// rbei_merge: result gathering and output register
// Packs the three lanes' position and velocity into one result beat and
// holds it until the downstream side takes it.
// ============================================================================
module rbei_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic signed [rbei_pkg::DATA_W-1:0]  i_pos [rbei_pkg::NUM_AXES],
    input  logic signed [rbei_pkg::DATA_W-1:0]  i_vel [rbei_pkg::NUM_AXES],
    output logic                                o_can_load,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [2*rbei_pkg::NUM_AXES*rbei_pkg::DATA_W-1:0] m_axis_tdata
);

    localparam int OUT_W = 2 * rbei_pkg::NUM_AXES * rbei_pkg::DATA_W;

    logic             r_valid, n_valid;
    logic [OUT_W-1:0] r_data, n_data;

    assign o_can_load = !r_valid || m_axis_tready;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid && !m_axis_tready;
        if (i_load) begin
            n_valid = 1'b1;
            for (int a = 0; a < rbei_pkg::NUM_AXES; a++) begin
                n_data[a*rbei_pkg::DATA_W +: rbei_pkg::DATA_W] = i_pos[a];
                n_data[(rbei_pkg::NUM_AXES+a)*rbei_pkg::DATA_W +: rbei_pkg::DATA_W] = i_vel[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

endmodule

>>> verif/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for rigid_body_euler_integrator
// Drives accelerate, add-force, step and set-position beats with random
// bursts and gaps, stalls the result side on its own pattern, and checks
// every result beat against a Q16.16 model of the body kept in a scoreboard.
// ============================================================================
class integrator_scoreboard;
    bit                 grav_on;
    bit signed [31:0]   grav_accel;
    bit [30:0]          inv_mass;
    bit [16:0]          damp_q;
    bit signed [31:0]   pos [3];
    bit signed [31:0]   vel [3];
    bit signed [31:0]   acc [3];
    bit [191:0]         expected_states [$];
    int                 mismatches;

    function new();
        grav_on    = 1'b0;
        grav_accel = rbei_pkg::GRAV_RESET;
        inv_mass   = rbei_pkg::IMASS_RESET;
        damp_q     = rbei_pkg::DAMP_RESET;
        for (int i = 0; i < 3; i++) begin
            pos[i] = '0;
            vel[i] = '0;
            acc[i] = '0;
        end
        mismatches = 0;
    endfunction

    function bit signed [31:0] clamp(longint v);
        if (v > longint'(32'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -longint'(64'sh8000_0000)) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function bit signed [31:0] sat_add(longint a, longint b);
        return clamp(a + b);
    endfunction

    // Exact product, plus half an LSB, floor-shifted by s, then clamped.
    function bit signed [31:0] round_mul(longint a, longint b, int s);
        longint q;
        q = a * b + (longint'(1) << (s - 1));
        return clamp(q >>> s);
    endfunction

    function void set_register(rbei_pkg::t_cfg_idx idx, logic [31:0] value);
        case (idx)
            rbei_pkg::CFG_GRAV_EN: grav_on    = value[0];
            rbei_pkg::CFG_GRAV:    grav_accel = value;
            rbei_pkg::CFG_IMASS:   inv_mass   = value[30:0];
            default:               damp_q     = value[16:0];
        endcase
    endfunction

    // Advance the body by one accepted beat and queue the state it yields.
    function void integrate_item(rbei_pkg::t_op op, logic [31:0] vx, logic [31:0] vy,
                                 logic [31:0] vz, logic [15:0] dt);
        bit signed [31:0] vec [3];
        bit signed [31:0] v_new;
        longint           vsum;
        bit [191:0]       state;
        vec[0] = vx;
        vec[1] = vy;
        vec[2] = vz;
        case (op)
            rbei_pkg::OP_ACCEL: begin
                for (int i = 0; i < 3; i++) acc[i] = sat_add(acc[i], vec[i]);
            end
            rbei_pkg::OP_FORCE: begin
                for (int i = 0; i < 3; i++) begin
                    acc[i] = sat_add(acc[i], round_mul(vec[i], longint'(inv_mass), 16));
                end
            end
            rbei_pkg::OP_STEP: begin
                if (grav_on) begin
                    acc[rbei_pkg::AXIS_Y] = sat_add(acc[rbei_pkg::AXIS_Y],
                                                    round_mul(grav_accel, longint'(dt), 16));
                end
                for (int i = 0; i < 3; i++) begin
                    v_new  = sat_add(vel[i], round_mul(acc[i], longint'(dt), 16));
                    vsum   = longint'(vel[i]) + longint'(v_new);
                    pos[i] = sat_add(pos[i], round_mul(vsum, longint'(dt), 17));
                    vel[i] = round_mul(v_new, longint'(damp_q), 16);
                    acc[i] = '0;
                end
            end
            default: begin
                for (int i = 0; i < 3; i++) pos[i] = vec[i];
            end
        endcase
        state = {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
        expected_states.push_back(state);
    endfunction

    function void check_result(logic [191:0] got);
        string      field_name [6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};
        bit [191:0] want;
        if (expected_states.size() == 0) begin
            $display("%0t: result beat with nothing expected, got %h", $time, got);
            mismatches++;
            return;
        end
        want = expected_states.pop_front();
        for (int f = 0; f < 6; f++) begin
            if (want[f*32 +: 32] !== got[f*32 +: 32]) begin
                $display("%0t: %s expected %0d, got %0d", $time, field_name[f],
                         $signed(want[f*32 +: 32]), $signed(got[f*32 +: 32]));
                mismatches++;
            end
        end
    endfunction

    function int pending();
        return expected_states.size();
    endfunction
endclass

module tb_top;

    // The run sends about 1250 items; the slowest legal item is a gravity step
    // with its handoff to the output, stretched by a sender gap and a receiver
    // stall.
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 150;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [31:0]   i_cfg_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    // tdata: vec_x[31:0], vec_y[63:32], vec_z[95:64], time_step[111:96]
    logic [111:0]  s_axis_tdata;
    // tuser: operation[1:0]
    logic [1:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, 32 bits each from bit 0
    logic [191:0]  m_axis_tdata;

    integrator_scoreboard sb = new();

    int burst_left = 0;
    int rx_style   = 0;
    int rx_hold    = 0;
    int rx_ticks   = 0;
    int cycle_count = 0;

    rigid_body_euler_integrator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Every accepted result beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
    end

    // Result-side back-pressure. The style is redrawn periodically at random:
    // always ready, coin-flip ready, or occasional long stalls, so stalls land
    // on every phase of the block's sequencer and some stretches have none.
    always @(negedge i_clk) begin
        rx_ticks++;
        if (rx_ticks % 300 == 0) begin
            rx_style = $urandom_range(0, 2);
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: begin
                    if ($urandom_range(0, 5) == 0) begin
                        rx_hold = $urandom_range(1, 11);
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Mostly modest Q16.16 values when tame, so the body state evolves
    // instead of sitting at the rails; otherwise also extremes and raw random words.
    function automatic logic [31:0] pick_q16(input bit tame);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (tame && sel < 8) begin
            return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        end
        case (sel)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_dt();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(1, 4095));
            default: return 16'($urandom);
        endcase
    endfunction

    // Send one input beat. The sender runs in bursts; between bursts tvalid
    // usually drops for a random gap. Long bursts with no gap are mixed in.
    task automatic send_item(input rbei_pkg::t_op op, input logic [31:0] vx,
                             input logic [31:0] vy, input logic [31:0] vz,
                             input logic [15:0] dt);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {dt, vz, vy, vx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.integrate_item(op, vx, vy, vz, dt);
    endtask

    // Stop sending and wait until every predicted beat has come back, then idle
    // so the sequencer is surely back at rest.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input rbei_pkg::t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_register(idx, value);
    endtask

    task automatic configure(input bit grav_en, input logic [31:0] grav,
                             input logic [30:0] imass, input logic [16:0] damp);
        write_reg(rbei_pkg::CFG_GRAV_EN, {31'd0, grav_en});
        write_reg(rbei_pkg::CFG_GRAV, grav);
        write_reg(rbei_pkg::CFG_IMASS, {1'b0, imass});
        write_reg(rbei_pkg::CFG_DAMP, {15'd0, damp});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random traffic: mostly well-formed frames (optional set-position, up to
    // three accelerate or add-force beats, then a step), the rest single beats
    // with arbitrary operation and content.
    task automatic run_random_phase(input int n_items);
        int sent;
        int n_push;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_item(rbei_pkg::OP_SETPOS, pick_q16(1), pick_q16(1), pick_q16(1),
                              16'($urandom));
                    sent++;
                end
                n_push = $urandom_range(0, 3);
                repeat (n_push) begin
                    send_item($urandom_range(0, 1) ? rbei_pkg::OP_FORCE
                                                   : rbei_pkg::OP_ACCEL,
                              pick_q16(1), pick_q16(1), pick_q16(1), 16'($urandom));
                    sent++;
                end
                send_item(rbei_pkg::OP_STEP, $urandom, $urandom, $urandom, pick_dt());
                sent++;
            end else begin
                send_item(rbei_pkg::t_op'($urandom_range(0, 3)), pick_q16(0), pick_q16(0),
                          pick_q16(0), pick_dt());
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = rbei_pkg::CFG_GRAV_EN;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = rbei_pkg::OP_ACCEL;
        m_axis_tready = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset settings: no gravity, unit inverse
        // mass, unit damping.
        send_item(rbei_pkg::OP_SETPOS, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 16'hFFFF);
        // Accumulator saturation in both directions.
        send_item(rbei_pkg::OP_ACCEL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'h0000);
        send_item(rbei_pkg::OP_ACCEL, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 16'h1234);
        // Full-scale step, then a zero-length step that only damps and clears.
        send_item(rbei_pkg::OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(rbei_pkg::OP_STEP, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0F0F_F0F0, 16'h0000);
        send_item(rbei_pkg::OP_FORCE, 32'h4000_0000, 32'hC000_0000, 32'h0000_0001, 16'h8000);
        send_item(rbei_pkg::OP_STEP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h8000);
        // Position at the rails, then pushed further so the position add saturates.
        send_item(rbei_pkg::OP_SETPOS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'h0000);
        send_item(rbei_pkg::OP_ACCEL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_item(rbei_pkg::OP_STEP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
        // Sub-LSB products exercise the round-half-up rule on both signs.
        send_item(rbei_pkg::OP_ACCEL, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_8000, 16'h0001);
        send_item(rbei_pkg::OP_STEP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0001);
        send_item(rbei_pkg::OP_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(rbei_pkg::OP_FORCE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
        send_item(rbei_pkg::OP_STEP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0001);
        send_item(rbei_pkg::OP_SETPOS, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0000);

        // Random phases, each under its own register setting. The first
        // three cover gravity on at its usual value and both sets of extremes,
        // including damping above one and zero inverse mass.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: configure(1'b1, rbei_pkg::GRAV_RESET, rbei_pkg::IMASS_RESET, 17'd64000);
                1: configure(1'b1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 17'h1FFFF);
                2: configure(1'b1, 32'h8000_0000, 31'd0, 17'd0);
                3: configure(1'b0, $urandom, 31'($urandom), 17'($urandom));
                default: configure(1'($urandom_range(0, 1)), pick_q16(1),
                                   ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                               : 31'($urandom_range(0, 1 << 18)),
                                   ($urandom_range(0, 1) == 0) ? 17'($urandom_range(60000, 65536))
                                                               : 17'($urandom_range(0, 131071)));
            endcase
            run_random_phase(PHASE_ITEMS);
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rbei_pkg.sv
rtl/rbei_lane.sv
rtl/rbei_merge.sv
rtl/rigid_body_euler_integrator.sv
verif/tb_top.sv
